/* rtl/gbnsw_pkg.sv */
// Shared types and constants for the go-back-n sender window.
// No dependencies; imported by every module of the block except gbnsw_ram.
package gbnsw_pkg;

   localparam int DEF_SEQ_BITS     = 3;
   localparam int DEF_WINDOW       = 4;
   localparam int DEF_PAYLOAD_BITS = 32;

   typedef enum logic [1:0] {
      KIND_SEND    = 2'd0,
      KIND_ACK     = 2'd1,
      KIND_TIMEOUT = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      TMR_NONE    = 2'd0,
      TMR_START   = 2'd1,
      TMR_RESTART = 2'd2,
      TMR_STOP    = 2'd3
   } timer_cmd_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_RETX = 1'b1
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic take;       // request transaction accepted this cycle
      logic retx_step;  // load one retransmitted packet into the output register
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic out_free;     // output register can be loaded this cycle
      logic burst_start;  // current request is a timeout with packets outstanding
      logic burst_more;   // more packets follow the one being retransmitted
   } status_type;

endpackage

/* rtl/gbnsw_ram.sv */
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module gbnsw_ram #(
   parameter int WIDTH     = 32,
   parameter int DEPTH     = 4,
   parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/gbnsw_ctrl.sv */
// Controller: request handshake and retransmit burst sequencing.
// Depends on gbnsw_pkg.
module gbnsw_ctrl
   import gbnsw_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      cmd.take      = 1'b0;
      cmd.retx_step = 1'b0;
      req_stall     = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = !status.out_free;
            if (req_valid && status.out_free) begin
               cmd.take = 1'b1;
               if (status.burst_start) begin
                  state_in = ST_RETX;
               end
            end
         end
         ST_RETX: begin
            if (status.out_free) begin
               cmd.retx_step = 1'b1;
               if (!status.burst_more) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

/* rtl/gbnsw_dp.sv */
// Datapath: window pointers, packet store, burst counters and result register.
// Depends on gbnsw_pkg and gbnsw_ram.
module gbnsw_dp
   import gbnsw_pkg::*;
#(
   parameter int SEQ_BITS     = DEF_SEQ_BITS,
   parameter int WINDOW       = DEF_WINDOW,
   parameter int PAYLOAD_BITS = DEF_PAYLOAD_BITS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  cmd_type                 cmd,
   output status_type              status,
   input  logic [1:0]              req_kind,
   input  logic [PAYLOAD_BITS-1:0] req_payload,
   input  logic [SEQ_BITS-1:0]     req_ack_num,
   input  logic                    req_ack_ok,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic                    rsp_accepted,
   output logic                    rsp_tx_valid,
   output logic [SEQ_BITS-1:0]     rsp_tx_seq,
   output logic [PAYLOAD_BITS-1:0] rsp_tx_payload,
   output logic [1:0]              rsp_timer_cmd,
   output logic                    rsp_last
);

   localparam int ADDR_BITS = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int CNT_BITS  = SEQ_BITS + 1;
   localparam logic [SEQ_BITS-1:0] WIN_MASK = SEQ_BITS'(WINDOW - 1);
   localparam logic [CNT_BITS-1:0] WIN_CNT  = CNT_BITS'(WINDOW);
   localparam logic [SEQ_BITS-1:0] SEQ_ONE  = SEQ_BITS'(1);
   localparam logic [CNT_BITS-1:0] CNT_ONE  = CNT_BITS'(1);

   logic [SEQ_BITS-1:0] base_ff, base_in;
   logic [SEQ_BITS-1:0] next_ff, next_in;
   logic [CNT_BITS-1:0] idx_ff, idx_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;

   logic                    valid_ff, valid_in;
   logic                    acc_ff, acc_in;
   logic                    txv_ff, txv_in;
   logic [SEQ_BITS-1:0]     seq_ff, seq_in;
   logic [PAYLOAD_BITS-1:0] pay_ff, pay_in;
   logic [1:0]              tcmd_ff, tcmd_in;
   logic                    last_ff, last_in;

   logic [SEQ_BITS-1:0]     outst;
   logic                    full;
   logic [CNT_BITS-1:0]     idx_nxt;
   logic [SEQ_BITS-1:0]     retx_seq;
   logic [SEQ_BITS-1:0]     new_base;
   logic                    load;

   logic                    wr_en, rd_en;
   logic [ADDR_BITS-1:0]    wr_addr, rd_addr;
   logic [PAYLOAD_BITS-1:0] rd_data;

   gbnsw_ram #(
      .WIDTH (PAYLOAD_BITS),
      .DEPTH (WINDOW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_payload),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign outst    = next_ff - base_ff;
   assign full     = {1'b0, outst} >= WIN_CNT;
   assign idx_nxt  = idx_ff + CNT_ONE;
   assign retx_seq = base_ff + idx_ff[SEQ_BITS-1:0];
   assign new_base = req_ack_num + SEQ_ONE;

   assign status.out_free    = !valid_ff || !rsp_stall;
   assign status.burst_start = (req_kind == KIND_TIMEOUT) && (outst != '0);
   assign status.burst_more  = idx_nxt < cnt_ff;

   assign load = (cmd.take && !status.burst_start) || cmd.retx_step;

   always_comb begin
      base_in = base_ff;
      next_in = next_ff;
      idx_in  = idx_ff;
      cnt_in  = cnt_ff;
      acc_in  = 1'b0;
      txv_in  = 1'b0;
      seq_in  = '0;
      pay_in  = '0;
      tcmd_in = TMR_NONE;
      last_in = 1'b1;
      wr_en   = 1'b0;
      wr_addr = ADDR_BITS'(next_ff & WIN_MASK);
      rd_en   = 1'b0;
      rd_addr = ADDR_BITS'(base_ff & WIN_MASK);

      if (cmd.take) begin
         case (req_kind)
            KIND_SEND: begin
               if (!full) begin
                  wr_en   = 1'b1;
                  acc_in  = 1'b1;
                  txv_in  = 1'b1;
                  seq_in  = next_ff;
                  pay_in  = req_payload;
                  tcmd_in = (base_ff == next_ff) ? TMR_START : TMR_NONE;
                  next_in = next_ff + SEQ_ONE;
               end
            end
            KIND_ACK: begin
               if (req_ack_ok) begin
                  base_in = new_base;
                  tcmd_in = (new_base == next_ff) ? TMR_STOP : TMR_RESTART;
               end
            end
            KIND_TIMEOUT: begin
               if (status.burst_start) begin
                  // prefetch the packet at the window base
                  rd_en  = 1'b1;
                  idx_in = '0;
                  cnt_in = full ? WIN_CNT : {1'b0, outst};
               end else begin
                  tcmd_in = TMR_RESTART;
               end
            end
            default: begin
            end
         endcase
      end else if (cmd.retx_step) begin
         txv_in  = 1'b1;
         seq_in  = retx_seq;
         pay_in  = rd_data;
         tcmd_in = (idx_ff == '0) ? TMR_RESTART : TMR_NONE;
         last_in = !status.burst_more;
         if (status.burst_more) begin
            idx_in  = idx_nxt;
            rd_en   = 1'b1;
            rd_addr = ADDR_BITS'((retx_seq + SEQ_ONE) & WIN_MASK);
         end
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (valid_ff && !rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= SEQ_ONE;
         next_ff  <= SEQ_ONE;
         idx_ff   <= '0;
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         base_ff  <= base_in;
         next_ff  <= next_in;
         idx_ff   <= idx_in;
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         acc_ff  <= acc_in;
         txv_ff  <= txv_in;
         seq_ff  <= seq_in;
         pay_ff  <= pay_in;
         tcmd_ff <= tcmd_in;
         last_ff <= last_in;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_accepted   = acc_ff;
   assign rsp_tx_valid   = txv_ff;
   assign rsp_tx_seq     = seq_ff;
   assign rsp_tx_payload = pay_ff;
   assign rsp_timer_cmd  = tcmd_ff;
   assign rsp_last       = last_ff;

endmodule

/* rtl/go_back_n_sender_window.sv */
// Go-back-n sender window, top level.
// Send, ack and other requests: result registered in the cycle after acceptance, one
// request per cycle unless the output stalls. Timeout with packets outstanding: up to
// WINDOW go one per cycle unless stalled (store read pipelined one ahead); requests wait.
// Synchronous reset sets window base and next sequence to 1; packet store is not cleared.
// Depends on gbnsw_pkg, gbnsw_ctrl, gbnsw_dp, gbnsw_ram.
module go_back_n_sender_window
   import gbnsw_pkg::*;
#(
   parameter int SEQ_BITS     = DEF_SEQ_BITS,
   parameter int WINDOW       = DEF_WINDOW,
   parameter int PAYLOAD_BITS = DEF_PAYLOAD_BITS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [1:0]              req_kind,
   input  logic [PAYLOAD_BITS-1:0] req_payload,
   input  logic [SEQ_BITS-1:0]     req_ack_num,
   input  logic                    req_ack_ok,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic                    rsp_accepted,
   output logic                    rsp_tx_valid,
   output logic [SEQ_BITS-1:0]     rsp_tx_seq,
   output logic [PAYLOAD_BITS-1:0] rsp_tx_payload,
   output logic [1:0]              rsp_timer_cmd,
   output logic                    rsp_last
);

   cmd_type    cmd;
   status_type status;

   gbnsw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   gbnsw_dp #(
      .SEQ_BITS     (SEQ_BITS),
      .WINDOW       (WINDOW),
      .PAYLOAD_BITS (PAYLOAD_BITS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_kind       (req_kind),
      .req_payload    (req_payload),
      .req_ack_num    (req_ack_num),
      .req_ack_ok     (req_ack_ok),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_accepted   (rsp_accepted),
      .rsp_tx_valid   (rsp_tx_valid),
      .rsp_tx_seq     (rsp_tx_seq),
      .rsp_tx_payload (rsp_tx_payload),
      .rsp_timer_cmd  (rsp_timer_cmd),
      .rsp_last       (rsp_last)
   );

endmodule

/* sim/tb.sv */
// Self-checking testbench for the go-back-n sender window (go_back_n_sender_window).
// Directed table, then random traffic checked against a behavioral window model.
// Depends on gbnsw_pkg and the RTL of the block.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import gbnsw_pkg::*;

   localparam int SEQ_W        = DEF_SEQ_BITS;
   localparam int WIN          = DEF_WINDOW;
   localparam int PAY_W        = DEF_PAYLOAD_BITS;
   localparam int RESET_CYCLES = 9;
   localparam int RANDOM_ITEMS = 225;
   localparam int TAIL_CYCLES  = 20;
   localparam int LIMIT_CYCLES = 100000;
   localparam int IDLE_PCT     = 38;
   localparam logic [1:0] KIND_OTHER = 2'd3;

   typedef struct {
      logic                accepted;
      logic                tx_valid;
      logic [SEQ_W-1:0]    seq;
      logic [PAY_W-1:0]    payload;
      timer_cmd_type       tcmd;
      logic                last;
   } tx_result_type;

   typedef struct {
      logic [1:0]          kind;
      logic [PAY_W-1:0]    payload;
      logic [SEQ_W-1:0]    ack_num;
      logic                ack_ok;
      bit                  typed;
      tx_result_type       result;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_kind = 2'd0;
   logic [PAY_W-1:0] req_payload = '0;
   logic [SEQ_W-1:0] req_ack_num = '0;
   logic req_ack_ok = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_accepted;
   logic rsp_tx_valid;
   logic [SEQ_W-1:0] rsp_tx_seq;
   logic [PAY_W-1:0] rsp_tx_payload;
   logic [1:0] rsp_timer_cmd;
   logic rsp_last;

   // window model state
   logic [SEQ_W-1:0] win_base = SEQ_W'(1);
   logic [SEQ_W-1:0] next_seq_num = SEQ_W'(1);
   logic [PAY_W-1:0] sent_store [WIN];
   bit               slot_written [WIN] = '{default: 1'b0};

   tx_result_type step_out[$];
   tx_result_type expected_tx[$];
   stim_row_type  directed_rows[$];
   int  mismatches = 0;
   int  cycle_count = 0;
   bit  quiet = 1'b0;

   go_back_n_sender_window dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_kind       (req_kind),
      .req_payload    (req_payload),
      .req_ack_num    (req_ack_num),
      .req_ack_ok     (req_ack_ok),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_accepted   (rsp_accepted),
      .rsp_tx_valid   (rsp_tx_valid),
      .rsp_tx_seq     (rsp_tx_seq),
      .rsp_tx_payload (rsp_tx_payload),
      .rsp_timer_cmd  (rsp_timer_cmd),
      .rsp_last       (rsp_last)
   );

   always #10 clock = ~clock;

   function automatic tx_result_type empty_result();
      tx_result_type r;
      r.accepted = 1'b0;
      r.tx_valid = 1'b0;
      r.seq      = '0;
      r.payload  = '0;
      r.tcmd     = TMR_NONE;
      r.last     = 1'b1;
      return r;
   endfunction

   function automatic logic [SEQ_W-1:0] in_flight();
      logic [SEQ_W-1:0] n;
      n = next_seq_num - win_base;
      return n;
   endfunction

   // a timeout must never fetch a store slot that no send has filled
   function automatic bit retx_safe();
      int n;
      logic [SEQ_W-1:0] s;
      n = (in_flight() > WIN) ? WIN : int'(in_flight());
      for (int i = 0; i < n; i++) begin
         s = win_base + SEQ_W'(i);
         if (!slot_written[int'(s) % WIN]) return 1'b0;
      end
      return 1'b1;
   endfunction

   // advance the window model by one transaction; results land in step_out
   task automatic window_step(input logic [1:0] kind, input logic [PAY_W-1:0] payload,
                              input logic [SEQ_W-1:0] ack_num, input logic ack_ok);
      int n;
      logic [SEQ_W-1:0] s;
      tx_result_type r;
      begin
         step_out.delete();
         r = empty_result();
         n = int'(in_flight());
         case (kind)
            KIND_SEND: begin
               if (n < WIN) begin
                  sent_store[int'(next_seq_num) % WIN] = payload;
                  slot_written[int'(next_seq_num) % WIN] = 1'b1;
                  r.accepted = 1'b1;
                  r.tx_valid = 1'b1;
                  r.seq      = next_seq_num;
                  r.payload  = payload;
                  r.tcmd     = (win_base == next_seq_num) ? TMR_START : TMR_NONE;
                  next_seq_num = next_seq_num + 1'b1;
               end
               step_out.push_back(r);
            end
            KIND_ACK: begin
               if (ack_ok) begin
                  win_base = ack_num + 1'b1;
                  r.tcmd = (win_base == next_seq_num) ? TMR_STOP : TMR_RESTART;
               end
               step_out.push_back(r);
            end
            KIND_TIMEOUT: begin
               if (n > WIN) n = WIN;
               if (n == 0) begin
                  r.tcmd = TMR_RESTART;
                  step_out.push_back(r);
               end else begin
                  for (int i = 0; i < n; i++) begin
                     s = win_base + SEQ_W'(i);
                     r.tx_valid = 1'b1;
                     r.seq      = s;
                     r.payload  = sent_store[int'(s) % WIN];
                     r.tcmd     = (i == 0) ? TMR_RESTART : TMR_NONE;
                     r.last     = (i == n - 1);
                     step_out.push_back(r);
                  end
               end
            end
            default: step_out.push_back(r);
         endcase
      end
   endtask

   task automatic add_row(input logic [1:0] kind, input logic [PAY_W-1:0] payload,
                          input logic [SEQ_W-1:0] ack_num, input logic ack_ok,
                          input bit typed, input logic acc, input logic tv,
                          input logic [SEQ_W-1:0] seq, input logic [PAY_W-1:0] pay,
                          input timer_cmd_type tcmd);
      stim_row_type row;
      begin
         row.kind = kind;
         row.payload = payload;
         row.ack_num = ack_num;
         row.ack_ok = ack_ok;
         row.typed = typed;
         row.result = empty_result();
         row.result.accepted = acc;
         row.result.tx_valid = tv;
         row.result.seq = seq;
         row.result.payload = pay;
         row.result.tcmd = tcmd;
         directed_rows.push_back(row);
      end
   endtask

   // present one transaction, wait for it to be taken, then record what it should produce
   task automatic drive_item(input stim_row_type row);
      int gap;
      begin
         gap = 0;
         if (!quiet) while ($urandom_range(99) < IDLE_PCT) gap++;
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_valid   <= 1'b1;
         req_kind    <= row.kind;
         req_payload <= row.payload;
         req_ack_num <= row.ack_num;
         req_ack_ok  <= row.ack_ok;
         @(posedge clock);
         while (req_stall) @(posedge clock);
         window_step(row.kind, row.payload, row.ack_num, row.ack_ok);
         if (row.typed) expected_tx.push_back(row.result);
         else foreach (step_out[i]) expected_tx.push_back(step_out[i]);
      end
   endtask

   function automatic logic [PAY_W-1:0] rand_payload();
      case ($urandom_range(9))
         0: return '0;
         1: return '1;
         default: return PAY_W'($urandom);
      endcase
   endfunction

   task automatic report_mismatch(input string field, input logic [PAY_W-1:0] got,
                                  input logic [PAY_W-1:0] want);
      begin
         $display("%0t ERROR %s: got 'h%0h, expected 'h%0h", $realtime, field, got, want);
         mismatches++;
      end
   endtask

   // result side: random stall, compare every taken transaction with the oldest expectation
   always @(posedge clock) begin
      tx_result_type want;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_tx.size() == 0) begin
            report_mismatch("unexpected transaction, payload", rsp_tx_payload, '0);
         end else begin
            want = expected_tx.pop_front();
            if (rsp_accepted !== want.accepted)
               report_mismatch("accepted", PAY_W'(rsp_accepted), PAY_W'(want.accepted));
            if (rsp_tx_valid !== want.tx_valid)
               report_mismatch("tx_valid", PAY_W'(rsp_tx_valid), PAY_W'(want.tx_valid));
            if (rsp_tx_seq !== want.seq)
               report_mismatch("tx_seq", PAY_W'(rsp_tx_seq), PAY_W'(want.seq));
            if (rsp_tx_payload !== want.payload)
               report_mismatch("tx_payload", rsp_tx_payload, want.payload);
            if (rsp_timer_cmd !== want.tcmd)
               report_mismatch("timer_cmd", PAY_W'(rsp_timer_cmd), PAY_W'(want.tcmd));
            if (rsp_last !== want.last)
               report_mismatch("last", PAY_W'(rsp_last), PAY_W'(want.last));
         end
      end
      rsp_stall <= (!quiet && !reset) ? ($urandom_range(99) < IDLE_PCT) : 1'b0;
   end

   initial begin
      wait (cycle_count >= LIMIT_CYCLES);
      $display("Verification failed");
      $finish;
   end

   initial begin
      stim_row_type row;
      int pick;
      int k;

      // after reset: base = next = 1, store empty
      add_row(KIND_TIMEOUT, '0, 0, 0, 1, 0, 0, 0, '0, TMR_RESTART);
      add_row(KIND_SEND, 32'h0000_0000, 0, 0, 1, 1, 1, 1, 32'h0000_0000, TMR_START);
      add_row(KIND_SEND, 32'hFFFF_FFFF, 7, 1, 1, 1, 1, 2, 32'hFFFF_FFFF, TMR_NONE);
      add_row(KIND_SEND, 32'hA5A5_A5A5, 0, 0, 1, 1, 1, 3, 32'hA5A5_A5A5, TMR_NONE);
      add_row(KIND_SEND, 32'h5A5A_5A5A, 0, 0, 1, 1, 1, 4, 32'h5A5A_5A5A, TMR_NONE);
      // window full
      add_row(KIND_SEND, 32'h1234_5678, 0, 0, 1, 0, 0, 0, '0, TMR_NONE);
      add_row(KIND_TIMEOUT, '0, 0, 0, 0, 0, 0, 0, '0, TMR_NONE);
      // bad checksum and unknown kind are ignored
      add_row(KIND_ACK, '0, 7, 0, 1, 0, 0, 0, '0, TMR_NONE);
      add_row(KIND_OTHER, 32'hFFFF_FFFF, 7, 1, 1, 0, 0, 0, '0, TMR_NONE);
      add_row(KIND_ACK, '0, 2, 1, 1, 0, 0, 0, '0, TMR_RESTART);
      add_row(KIND_TIMEOUT, '0, 0, 0, 0, 0, 0, 0, '0, TMR_NONE);
      add_row(KIND_SEND, 32'hDEAD_BEEF, 0, 0, 1, 1, 1, 5, 32'hDEAD_BEEF, TMR_NONE);
      add_row(KIND_ACK, '0, 5, 1, 1, 0, 0, 0, '0, TMR_STOP);
      add_row(KIND_TIMEOUT, '0, 0, 0, 1, 0, 0, 0, '0, TMR_RESTART);
      // sequence numbers wrap through 7 -> 0
      add_row(KIND_SEND, 32'h8000_0001, 0, 0, 1, 1, 1, 6, 32'h8000_0001, TMR_START);
      add_row(KIND_SEND, 32'h7FFF_FFFE, 0, 0, 1, 1, 1, 7, 32'h7FFF_FFFE, TMR_NONE);
      add_row(KIND_SEND, 32'h0000_0001, 0, 0, 1, 1, 1, 0, 32'h0000_0001, TMR_NONE);
      add_row(KIND_SEND, 32'hFFFF_FFFE, 0, 0, 1, 1, 1, 1, 32'hFFFF_FFFE, TMR_NONE);
      add_row(KIND_TIMEOUT, '0, 0, 0, 0, 0, 0, 0, '0, TMR_NONE);
      add_row(KIND_ACK, '0, 0, 1, 1, 0, 0, 0, '0, TMR_RESTART);
      // ack beyond next: gap larger than the window
      add_row(KIND_ACK, '0, 3, 1, 1, 0, 0, 0, '0, TMR_RESTART);
      add_row(KIND_SEND, 32'h0F0F_0F0F, 0, 0, 1, 0, 0, 0, '0, TMR_NONE);
      add_row(KIND_TIMEOUT, '0, 0, 0, 0, 0, 0, 0, '0, TMR_NONE);
      add_row(KIND_ACK, '0, 1, 1, 1, 0, 0, 0, '0, TMR_STOP);
      add_row(KIND_TIMEOUT, '0, 0, 0, 1, 0, 0, 0, '0, TMR_RESTART);

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) drive_item(directed_rows[i]);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         quiet = (i >= 100 && i < 160);
         row.payload = rand_payload();
         row.ack_num = SEQ_W'($urandom);
         row.ack_ok  = 1'b1;
         row.typed   = 1'b0;
         row.result  = empty_result();
         pick = $urandom_range(99);
         if (pick < 45) begin
            row.kind = KIND_SEND;
            row.ack_ok = 1'($urandom_range(1));
         end else if (pick < 65) begin
            // ack of something in flight (or base - 1, a duplicate)
            row.kind = KIND_ACK;
            k = $urandom_range(int'(in_flight()));
            row.ack_num = win_base - 1'b1 + SEQ_W'(k);
         end else if (pick < 73) begin
            row.kind = KIND_ACK;
         end else if (pick < 83) begin
            row.kind = KIND_ACK;
            row.ack_ok = 1'b0;
         end else if (pick < 95) begin
            row.kind = KIND_TIMEOUT;
            row.ack_ok = 1'($urandom_range(1));
            if (!retx_safe()) begin
               row.kind = KIND_ACK;
               row.ack_num = next_seq_num - 1'b1;
               row.ack_ok = 1'b1;
            end
         end else begin
            row.kind = KIND_OTHER;
            row.ack_ok = 1'($urandom_range(1));
         end
         drive_item(row);
      end
      quiet = 1'b0;
      req_valid <= 1'b0;

      while (expected_tx.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
